[src/rdc_pkg.sv]
// Package for the radix digit converter: widths, radix limits and the
// command and status structs between controller and datapath. No dependencies.
package rdc_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int STORE_DEPTH = 64;

  localparam int DIGIT_W   = 6;
  localparam int CNT_W     = 7;
  localparam int RADIX_W   = 7;
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(64);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  typedef struct packed {
    logic load;      // latch a new value, clear the digit count
    logic div_step;  // one restoring division step
    logic store;     // write the remainder to the digit store
    logic rd_issue;  // read the digit store at the read pointer
    logic rd_next;   // step the read pointer toward the least significant digit
  } rdc_cmd_t;

  typedef struct packed {
    logic bit_last;   // final division step of this digit
    logic conv_done;  // quotient is zero or the digit limit is reached
    logic rd_last;    // read pointer is at the least significant digit
  } rdc_status_t;

endpackage

[src/rdc_ctrl.sv]
// Controller state machine for the radix digit converter.
// Depends on rdc_pkg for the command and status structs.
module rdc_ctrl import rdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  rdc_status_t status_i,
  output rdc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = status_i.conv_done ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/rdc_datapath.sv]
// Datapath for the radix digit converter: radix register, bit-serial divider,
// digit store and output read register. Depends on rdc_pkg.
module rdc_datapath import rdc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  input  logic [63:0]           value_i,
  input  rdc_cmd_t              cmd_i,
  output rdc_status_t           status_o,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic [CNT_W-1:0]      digit_count_o,
  output logic                  last_digit_o
);

  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]     ptr_q, ptr_d;
  logic [DIGIT_W-1:0]    rd_q;
  logic [DIGIT_W-1:0]    mem [STORE_DEPTH];

  logic [RADIX_W-1:0] trial;
  logic               ge;

  // clamp the radix into the supported range
  always_comb begin
    radix_d = radix_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (cfg_wdata_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = cfg_wdata_i;
      end
    end
  end

  // remainder stays below the radix, so its low six bits carry it
  assign trial = {rem_q[RADIX_W-2:0], quo_q[VALUE_BITS-1]};
  assign ge    = (trial >= radix_q);

  always_comb begin
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_cnt_d = bit_cnt_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    if (cmd_i.load) begin
      quo_d     = value_i[VALUE_BITS-1:0];
      rem_d     = '0;
      bit_cnt_d = '0;
      cnt_d     = '0;
    end
    if (cmd_i.div_step) begin
      rem_d     = ge ? (trial - radix_q) : trial;
      quo_d     = {quo_q[VALUE_BITS-2:0], ge};
      bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
    end
    if (cmd_i.store) begin
      cnt_d     = cnt_q + CNT_W'(1);
      rem_d     = '0;
      bit_cnt_d = '0;
      ptr_d     = cnt_q[ADDR_W-1:0];
    end
    if (cmd_i.rd_next) begin
      ptr_d = ptr_q - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q   <= RADIX_RESET;
      quo_q     <= '0;
      rem_q     <= '0;
      bit_cnt_q <= '0;
      cnt_q     <= '0;
      ptr_q     <= '0;
    end else begin
      radix_q   <= radix_d;
      quo_q     <= quo_d;
      rem_q     <= rem_d;
      bit_cnt_q <= bit_cnt_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[cnt_q[ADDR_W-1:0]] <= rem_q[DIGIT_W-1:0];
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[ptr_q];
    end
  end

  assign status_o.bit_last  = (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1));
  assign status_o.conv_done = (quo_q == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign status_o.rd_last   = (ptr_q == '0);

  assign digit_o       = rd_q;
  assign digit_count_o = cnt_q;
  assign last_digit_o  = (ptr_q == '0);

endmodule

[src/radix_digit_converter.sv]
// Radix digit converter: one 64-bit value in, its digits out, most significant first.
// Each digit takes 64 steps of the bit-serial divider plus a store; the digits are then
// read back through the registered digit store. One value is converted at a time.
// Reset (rst_ni, asynchronous, active low) returns the radix to 10 and idles the block.
module radix_digit_converter import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic [CNT_W-1:0]   digit_count_o,
  output logic               last_digit_o
);

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rdc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

[verif/tb_radix_digit_converter.sv]
// Testbench for radix_digit_converter: directed and random values under several radix
// settings, checked digit by digit against a scoreboard with its own divide-by-radix model.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`timescale 1ns / 100ps

module tb_radix_digit_converter;
  import rdc_pkg::*;

  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_GAP         = 200;
  localparam int LONG_HOLD       = 2500;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 17;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic [DIGIT_W-1:0] digit;
    logic [CNT_W-1:0]   count;
    logic               is_last;
  } digit_t;

  class digit_scoreboard;
    digit_t             pending_q[$];
    logic [RADIX_W-1:0] radix;
    int                 errors;
    int                 values_seen;
    int                 digits_checked;

    function new();
      radix          = RADIX_RESET;
      errors         = 0;
      values_seen    = 0;
      digits_checked = 0;
    endfunction

    // Mirror the register clamp.
    function void set_radix(logic [RADIX_W-1:0] wdata);
      if (wdata < RADIX_MIN) radix = RADIX_MIN;
      else if (wdata > RADIX_MAX) radix = RADIX_MAX;
      else radix = wdata;
    endfunction

    // Divide down to zero, then queue the digits most significant first.
    function void note_value(logic [63:0] value);
      logic [63:0]        quo;
      logic [63:0]        base;
      logic [DIGIT_W-1:0] rems [MAX_DIGITS];
      int                 n;
      digit_t             d;
      quo  = value & (ALL_ONES >> (64 - VALUE_BITS));
      base = 64'(radix);
      n    = 0;
      if (quo == 0) begin
        rems[0] = '0;
        n = 1;
      end else begin
        while (quo != 0 && n < MAX_DIGITS) begin
          rems[n] = DIGIT_W'(quo % base);
          quo = quo / base;
          n++;
        end
      end
      for (int k = n - 1; k >= 0; k--) begin
        d.digit   = rems[k];
        d.count   = CNT_W'(n);
        d.is_last = (k == 0);
        pending_q.push_back(d);
      end
      values_seen++;
    endfunction

    function void check_digit(logic [DIGIT_W-1:0] digit, logic [CNT_W-1:0] count,
                              logic is_last);
      digit_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected digit transaction: digit %0d, digit_count %0d, last_digit %0b",
               digit, count, is_last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      digits_checked++;
      if (digit !== e.digit) begin
        $error("digit mismatch: expected %0d, actual %0d", e.digit, digit);
        errors++;
      end
      if (count !== e.count) begin
        $error("digit_count mismatch: expected %0d, actual %0d", e.count, count);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last_digit mismatch: expected %0b, actual %0b", e.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [RADIX_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [63:0]        value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DIGIT_W-1:0] digit_o;
  logic [CNT_W-1:0]   digit_count_o;
  logic               last_digit_o;

  digit_scoreboard sb = new();
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int radix_writes    = 0;

  radix_digit_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_digit_o  (last_digit_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: check each digit transaction, then pick ready for the next cycle.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_digit(digit_o, digit_count_o, last_digit_o);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Valid stays high between back-to-back transactions; drop it only for a gap.
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_value(v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] wdata);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_radix(wdata);
    radix_writes++;
  endtask

  // Mostly short values; a share of full-width ones, zero and all ones.
  function automatic logic [63:0] rand_value();
    int sel;
    int w;
    sel = $urandom_range(0, 99);
    w   = $urandom_range(1, 20);
    if (sel < 5) return '0;
    if (sel < 10) return ALL_ONES;
    if (sel < 35) return {$urandom, $urandom};
    return {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
  endfunction

  initial begin
    logic [RADIX_W-1:0] radix_plan [NUM_PHASES];
    radix_plan = '{7'd1, 7'd100, 7'd10, 7'd7, 7'd16, 7'd36, 7'd0};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset radix, clamped radix writes, zero, extremes of the value.
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(ALL_ONES);
    send_value(64'd12345);
    write_radix(7'd0);
    send_value(ALL_ONES);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd0);
    send_value(64'd1);
    write_radix(7'd1);
    send_value(64'h5555_5555_5555_5555);
    write_radix(7'd127);
    send_value(ALL_ONES);
    send_value(64'd63);
    send_value(64'd64);
    send_value(64'd0);
    write_radix(7'd65);
    send_value(64'h0123_4567_89AB_CDEF);
    write_radix(7'd64);
    send_value(64'hFFFF_FFFF_0000_0000);
    write_radix(7'd3);
    send_value(ALL_ONES);
    send_value(64'd2);
    write_radix(7'd36);
    send_value(64'h0000_00FF_FFFF_FFFF);

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) radix_plan[p] = RADIX_W'($urandom_range(0, 127));
      write_radix(radix_plan[p]);
      if (p < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 59;
      end else if (p < 5) begin
        send_idle_pct = 59;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Hold the output off long enough for the input side to back up.
      if (p == 3) hold_left = LONG_HOLD;
      repeat (ITEMS_PER_PHASE) send_value(rand_value());
    end

    wait_drained();
    repeat (END_GAP) @(posedge clk_i);

    $display("Converted %0d values into %0d checked digits over %0d radix writes.",
             sb.values_seen, sb.digits_checked, radix_writes);
    $display("Radix range covered 2 to 64 with clamped writes, zero and full-width values.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
